// File: rtl/scc_pkg.sv
package scc_pkg;

    localparam int MODE_W   = 2;
    localparam int FIELD_W  = 10;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 13;
    localparam int CFG_W    = 11;

    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd2;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] source_node;
        logic [FIELD_W-1:0] target_node;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } result_t;

endpackage

// File: rtl/scc_ram.sv
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/scc_match.sv
// edge filter: tail/head orientation by pass, hit when the selected end is v and the peer is a live node
module scc_match #(
    parameter int NODE_W = 10,
    parameter int NC_W   = 11
) (
    input  logic [2*NODE_W-1:0] edge_word,
    input  logic [NODE_W-1:0]   v,
    input  logic [NC_W-1:0]     n,
    input  logic                fwd,
    output logic                hit,
    output logic [NODE_W-1:0]   peer
);

    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [NODE_W-1:0] a;

    assign tail = edge_word[2*NODE_W-1:NODE_W];
    assign head = edge_word[NODE_W-1:0];
    assign a    = fwd ? tail : head;
    assign peer = fwd ? head : tail;
    assign hit  = (a == v) && (NC_W'(peer) < n);

endmodule

// File: rtl/strongly_connected_components.sv
// channel   direction  handshake              payload
// cmd       in         start & !busy          scc_pkg::cmd_t
// result    out        done (one cycle)       scc_pkg::result_t
// cfg       in         cfg_valid & cfg_ready  node_count (11 bits)
//
// Add and clear answer in the cycle after start, query after S_QRY; busy stays low for add/clear.
// Compute: two visited clears over the n nodes, then per walked node a scan of
// all stored edges through the shared match unit, one edge at a time via S_SC_RD,
// S_SC_EDGE and S_SC_VIS. The edge RAM read port sets the pace.
// Reset is asynchronous; no clearing pass is needed after it.
// The receiver cannot stall: done is high for exactly one cycle per result word.
module strongly_connected_components #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  scc_pkg::cmd_t               cmd,
    output logic                        done,
    output scc_pkg::result_t            result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [scc_pkg::CFG_W-1:0]   cfg_data
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NC_W   = $clog2(MAX_NODES + 1);
    localparam int EA_W   = $clog2(MAX_EDGES);
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int STK_W  = NODE_W + EC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_QRY, S_CLR, S_P1_RD, S_P1_CHK, S_P2_TEST, S_P2_RDF, S_P2_CHK,
        S_SC_RD, S_SC_EDGE, S_SC_VIS, S_POP_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [EC_W-1:0]        edge_total_reg, edge_total_next;
    logic [scc_pkg::CFG_W-1:0] node_count_reg;
    logic [NC_W-1:0]        label_n_reg, label_n_next;
    logic [NC_W-1:0]        comp_reg, comp_next;
    logic [NC_W-1:0]        n_reg, n_next;
    logic                   pass2_reg, pass2_next;
    logic [NC_W-1:0]        s_reg, s_next;
    logic [NC_W-1:0]        fin_reg, fin_next;
    logic [NC_W-1:0]        sp_reg, sp_next;
    logic [NODE_W-1:0]      top_v_reg, top_v_next;
    logic [EC_W-1:0]        top_cur_reg, top_cur_next;
    logic [NODE_W-1:0]      peer_reg, peer_next;
    logic                   q_bad_reg, q_bad_next;
    logic                   q_zero_reg, q_zero_next;
    logic                   done_reg, done_next;
    scc_pkg::result_t       result_reg, result_next;

    logic [NC_W-1:0]        n_eff;
    logic                   accept;
    logic                   src_bad, dst_bad;

    logic                   e_we;
    logic [EA_W-1:0]        e_raddr;
    logic [2*NODE_W-1:0]    e_rdata;
    logic                   v_we, v_wdata;
    logic [NODE_W-1:0]      v_waddr, v_raddr;
    logic                   v_rdata;
    logic                   f_we;
    logic [NODE_W-1:0]      f_raddr;
    logic [NODE_W-1:0]      f_rdata;
    logic                   k_we;
    logic [STK_W-1:0]       k_rdata;
    logic                   l_we;
    logic [NODE_W-1:0]      l_waddr, l_raddr;
    logic [NODE_W-1:0]      l_rdata;
    logic                   m_hit;
    logic [NODE_W-1:0]      m_peer;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NC_W'(1);
        end
        else if (32'(node_count_reg) > 32'(MAX_NODES))
        begin
            n_eff = NC_W'(MAX_NODES);
        end
        else
        begin
            n_eff = NC_W'(node_count_reg);
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign src_bad   = 32'(cmd.source_node) >= 32'(n_eff);
    assign dst_bad   = 32'(cmd.target_node) >= 32'(n_eff);

    assign e_we = accept && (cmd.mode == scc_pkg::MODE_ADD) && !src_bad && !dst_bad
                  && (edge_total_reg != EC_W'(MAX_EDGES));
    assign e_raddr = EA_W'(top_cur_reg);
    assign f_raddr = NODE_W'(s_reg - NC_W'(1));
    assign l_raddr = NODE_W'(cmd.source_node);

    scc_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(EA_W'(edge_total_reg)),
        .wdata({NODE_W'(cmd.source_node), NODE_W'(cmd.target_node)}),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_finish_ram (
        .clk(clk), .we(f_we), .waddr(NODE_W'(fin_reg)), .wdata(top_v_reg),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    scc_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk(clk), .we(k_we), .waddr(NODE_W'(sp_reg - NC_W'(1))),
        .wdata({top_v_reg, EC_W'(top_cur_reg + EC_W'(1))}),
        .raddr(NODE_W'(sp_reg - NC_W'(2))), .rdata(k_rdata)
    );

    scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_label_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(NODE_W'(comp_reg)),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    scc_match #(.NODE_W(NODE_W), .NC_W(NC_W)) u_match (
        .edge_word(e_rdata), .v(top_v_reg), .n(n_reg), .fwd(!pass2_reg),
        .hit(m_hit), .peer(m_peer)
    );

    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        label_n_next    = label_n_reg;
        comp_next       = comp_reg;
        n_next          = n_reg;
        pass2_next      = pass2_reg;
        s_next          = s_reg;
        fin_next        = fin_reg;
        sp_next         = sp_reg;
        top_v_next      = top_v_reg;
        top_cur_next    = top_cur_reg;
        peer_next       = peer_reg;
        q_bad_next      = q_bad_reg;
        q_zero_next     = q_zero_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        v_we            = 1'b0;
        v_waddr         = NODE_W'(s_reg);
        v_wdata         = 1'b0;
        v_raddr         = NODE_W'(s_reg);
        f_we            = 1'b0;
        k_we            = 1'b0;
        l_we            = 1'b0;
        l_waddr         = top_v_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.mode)
                        scc_pkg::MODE_ADD:
                        begin
                            done_next = 1'b1;
                            result_next.status = scc_pkg::ST_OK;
                            if (src_bad || dst_bad)
                            begin
                                result_next.status = scc_pkg::ST_BAD_NODE;
                            end
                            else if (edge_total_reg == EC_W'(MAX_EDGES))
                            begin
                                result_next.status = scc_pkg::ST_FULL;
                            end
                            else
                            begin
                                edge_total_next = EC_W'(edge_total_reg + EC_W'(1));
                            end
                            result_next.value = scc_pkg::VALUE_W'(edge_total_next);
                        end
                        scc_pkg::MODE_COMPUTE:
                        begin
                            n_next     = n_eff;
                            s_next     = '0;
                            fin_next   = '0;
                            pass2_next = 1'b0;
                            state_next = S_CLR;
                        end
                        scc_pkg::MODE_QUERY:
                        begin
                            q_bad_next  = src_bad;
                            q_zero_next = 32'(cmd.source_node) >= 32'(label_n_reg);
                            state_next  = S_QRY;
                        end
                        scc_pkg::MODE_CLEAR:
                        begin
                            edge_total_next = '0;
                            done_next       = 1'b1;
                            result_next     = '{status: scc_pkg::ST_OK, value: '0};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_QRY:
            begin
                done_next = 1'b1;
                result_next.status = q_bad_reg ? scc_pkg::ST_BAD_NODE : scc_pkg::ST_OK;
                result_next.value  = (q_bad_reg || q_zero_reg) ? '0
                                     : scc_pkg::VALUE_W'(l_rdata);
                state_next = S_IDLE;
            end
            S_CLR:
            begin
                v_we = 1'b1;
                if (s_reg == NC_W'(n_reg - NC_W'(1)))
                begin
                    if (pass2_reg)
                    begin
                        s_next     = fin_reg;
                        comp_next  = '0;
                        state_next = S_P2_TEST;
                    end
                    else
                    begin
                        s_next     = '0;
                        state_next = S_P1_RD;
                    end
                end
                else
                begin
                    s_next = NC_W'(s_reg + NC_W'(1));
                end
            end
            S_P1_RD:
            begin
                if (s_reg == n_reg)
                begin
                    pass2_next = 1'b1;
                    s_next     = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_P1_CHK;
                end
            end
            S_P1_CHK:
            begin
                if (v_rdata)
                begin
                    s_next     = NC_W'(s_reg + NC_W'(1));
                    state_next = S_P1_RD;
                end
                else
                begin
                    v_we         = 1'b1;
                    v_wdata      = 1'b1;
                    top_v_next   = NODE_W'(s_reg);
                    top_cur_next = '0;
                    sp_next      = NC_W'(1);
                    state_next   = S_SC_RD;
                end
            end
            S_P2_TEST:
            begin
                if (s_reg == '0)
                begin
                    label_n_next = n_reg;
                    done_next    = 1'b1;
                    result_next  = '{status: scc_pkg::ST_OK,
                                     value: scc_pkg::VALUE_W'(comp_reg)};
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_P2_RDF;
                end
            end
            S_P2_RDF:
            begin
                top_v_next = f_rdata;
                v_raddr    = f_rdata;
                state_next = S_P2_CHK;
            end
            S_P2_CHK:
            begin
                if (v_rdata)
                begin
                    s_next     = NC_W'(s_reg - NC_W'(1));
                    state_next = S_P2_TEST;
                end
                else
                begin
                    v_we         = 1'b1;
                    v_waddr      = top_v_reg;
                    v_wdata      = 1'b1;
                    l_we         = 1'b1;
                    top_cur_next = '0;
                    sp_next      = NC_W'(1);
                    state_next   = S_SC_RD;
                end
            end
            S_SC_RD:
            begin
                if (top_cur_reg >= edge_total_reg)
                begin
                    // pop
                    if (!pass2_reg)
                    begin
                        f_we     = 1'b1;
                        fin_next = NC_W'(fin_reg + NC_W'(1));
                    end
                    sp_next = NC_W'(sp_reg - NC_W'(1));
                    if (sp_reg == NC_W'(1))
                    begin
                        if (pass2_reg)
                        begin
                            comp_next  = NC_W'(comp_reg + NC_W'(1));
                            s_next     = NC_W'(s_reg - NC_W'(1));
                            state_next = S_P2_TEST;
                        end
                        else
                        begin
                            s_next     = NC_W'(s_reg + NC_W'(1));
                            state_next = S_P1_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_POP_WAIT;
                    end
                end
                else
                begin
                    state_next = S_SC_EDGE;
                end
            end
            S_SC_EDGE:
            begin
                if (m_hit)
                begin
                    peer_next  = m_peer;
                    v_raddr    = m_peer;
                    state_next = S_SC_VIS;
                end
                else
                begin
                    top_cur_next = EC_W'(top_cur_reg + EC_W'(1));
                    state_next   = S_SC_RD;
                end
            end
            S_SC_VIS:
            begin
                if (v_rdata)
                begin
                    top_cur_next = EC_W'(top_cur_reg + EC_W'(1));
                end
                else
                begin
                    k_we         = 1'b1;
                    v_we         = 1'b1;
                    v_waddr      = peer_reg;
                    v_wdata      = 1'b1;
                    l_we         = pass2_reg;
                    l_waddr      = peer_reg;
                    top_v_next   = peer_reg;
                    top_cur_next = '0;
                    sp_next      = NC_W'(sp_reg + NC_W'(1));
                end
                state_next = S_SC_RD;
            end
            S_POP_WAIT:
            begin
                top_v_next   = k_rdata[STK_W-1:EC_W];
                top_cur_next = k_rdata[EC_W-1:0];
                state_next   = S_SC_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_total_reg <= '0;
            node_count_reg <= scc_pkg::NODE_COUNT_RESET;
            label_n_reg    <= '0;
            comp_reg       <= '0;
            sp_reg         <= '0;
            fin_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            label_n_reg    <= label_n_next;
            comp_reg       <= comp_next;
            sp_reg         <= sp_next;
            fin_reg        <= fin_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        pass2_reg   <= pass2_next;
        s_reg       <= s_next;
        top_v_reg   <= top_v_next;
        top_cur_reg <= top_cur_next;
        peer_reg    <= peer_next;
        q_bad_reg   <= q_bad_next;
        q_zero_reg  <= q_zero_next;
        result_reg  <= result_next;
    end

    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (sp_reg == '0))
        else $error("walk stack not empty when idle");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_total_reg) <= 32'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fin_reg) <= 32'(MAX_NODES))
        else $error("finish count beyond node count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == scc_pkg::ST_FULL))
        |-> (edge_total_reg == EC_W'(MAX_EDGES)))
        else $error("full status with room in store");

    a_busy_no_done_add: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.mode == scc_pkg::MODE_COMPUTE)) |=> busy)
        else $error("compute did not hold busy");

endmodule
